// File: hw/rtl/ncsm_pkg.sv
// shared types, constants and helpers for the case-insensitive substring matcher
package ncsm_pkg;

  // needle register file geometry
  localparam int unsigned RegBytes  = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 64;
  localparam int unsigned RegIdxW   = 2;

  // register index, taken from paddr[4:3]
  localparam logic [RegIdxW-1:0] REG_NEEDLE_LOW  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_NEEDLE_HIGH = 2'd1;
  localparam logic [RegIdxW-1:0] REG_NEEDLE_LEN  = 2'd2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic       step;   // a text byte enters the chain
    logic       clear;  // end of haystack, drop all partial matches
    logic [7:0] text;   // case-folded text byte
  } cell_ctrl_t;

  // fold ascii upper case to lower case, everything else passes
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b - CHAR_UPPER_A + CHAR_LOWER_A;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ncsm_if.sv
// stream channel interfaces for haystack bytes and match results
interface ncsm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;
  logic       haystack_empty;

  modport source (output valid, output text_byte, output is_last, output haystack_empty,
                  input ready);
  modport sink   (input valid, input text_byte, input is_last, input haystack_empty,
                  output ready);
endinterface

interface ncsm_result_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

// File: hw/rtl/nocase_substring_match.sv
// top level of the case-insensitive streaming substring matcher
// the found result becomes valid in the cycle after the last byte's transfer
// throughput: one haystack byte per cycle while the result register is free or draining
// a new haystack may start in the cycle right after the last byte of the previous one if that result is taken
// reset: needle registers, length, match bits, sticky flag and output valid clear to zero
module nocase_substring_match #(
  parameter int unsigned MAX_NEEDLE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ncsm_pkg::ApbAddrW-1:0] paddr,
  input  logic [ncsm_pkg::ApbDataW-1:0] pwdata,
  output logic [ncsm_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  // streams
  ncsm_text_if.sink                     text_i,
  ncsm_result_if.source                 result_o
);
  import ncsm_pkg::*;

  // cells actually built: the register file holds at most sixteen needle bytes
  localparam int unsigned NumCells = (MAX_NEEDLE < RegBytes) ? MAX_NEEDLE : RegBytes;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [63:0]     needle_low_q, needle_high_q;
  logic [LenW-1:0] needle_len_q;
  logic            cfg_write;
  logic [RegIdxW-1:0] reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  // registers sit on 8-byte boundaries, low address bits are ignored
  assign reg_idx   = paddr[ApbAddrW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_NEEDLE_LOW:  needle_low_q  <= pwdata[63:0];
        REG_NEEDLE_HIGH: needle_high_q <= pwdata[63:0];
        REG_NEEDLE_LEN:  needle_len_q  <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NEEDLE_LOW:  prdata = needle_low_q;
      REG_NEEDLE_HIGH: prdata = needle_high_q;
      REG_NEEDLE_LEN:  prdata = {{(ApbDataW-LenW){1'b0}}, needle_len_q};
      default:         prdata = '0;
    endcase
  end

  // length saturates at the number of cells
  logic [LenW-1:0] eff_len;
  assign eff_len = (needle_len_q > LenW'(NumCells)) ? LenW'(NumCells) : needle_len_q;

  // ---------------------------------------------------------------------------
  // input side: a byte is taken whenever the result register is free or draining
  // ---------------------------------------------------------------------------
  logic       in_xfer;
  logic       out_valid_q, out_found_q;
  logic       sticky_q, sticky_d;
  cell_ctrl_t ctrl;

  assign text_i.ready = ~out_valid_q | result_o.ready;
  assign in_xfer      = text_i.valid & text_i.ready;

  // an empty flagged item carries no byte; an empty needle never moves the chain
  assign ctrl.step  = in_xfer & ~text_i.haystack_empty & (eff_len != '0);
  assign ctrl.clear = in_xfer & text_i.is_last;
  assign ctrl.text  = fold_case(text_i.text_byte);

  // ---------------------------------------------------------------------------
  // chain of match cells, each passes its prefix bit to the next in line
  // ---------------------------------------------------------------------------
  logic [127:0]        needle_all;
  logic [NumCells-1:0] match_bits;
  logic [NumCells-1:0] hit_bits;
  logic [NumCells-1:0] active_mask;

  assign needle_all = {needle_high_q, needle_low_q};

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_head
      // the empty prefix always matches
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_bits[g-1];
    end

    ncsm_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .len_i         (eff_len),
      .needle_byte_i (needle_all[8*g +: 8]),
      .prev_i        (prev),
      .match_o       (match_bits[g]),
      .hit_o         (hit_bits[g])
    );

    assign active_mask[g] = LenW'(g) < eff_len;
  end

  // ---------------------------------------------------------------------------
  // sticky found flag, cleared at the end of each haystack
  // ---------------------------------------------------------------------------
  logic found_now;

  assign found_now = sticky_q | (|hit_bits);

  always_comb begin
    sticky_d = found_now;
    if (ctrl.clear) begin
      sticky_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sticky_q <= 1'b0;
    end else begin
      sticky_q <= sticky_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register, loaded by the last byte of a haystack
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.clear) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.clear) begin
      out_found_q <= (eff_len == '0) | found_now;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.found = out_found_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // end of haystack leaves no partial match and no sticky flag behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (match_bits == '0) && !sticky_q)
    else $error("match state not cleared after last transfer");

  // last transfer always produces a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> result_o.valid)
    else $error("no result after last transfer");

  // empty needle reports found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear && (eff_len == '0) |=> result_o.found)
    else $error("empty needle did not report found");

  // no prefix bit beyond the needle length can be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(needle_len_q) |-> ((match_bits & ~active_mask) == '0))
    else $error("prefix bit set beyond needle length");

endmodule

// File: hw/rtl/ncsm_cell.sv
// one match cell: holds the prefix match bit for one needle position
module ncsm_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ncsm_pkg::cell_ctrl_t   ctrl_i,
  input  logic [ncsm_pkg::LenW-1:0] len_i,
  input  logic [7:0]             needle_byte_i,
  input  logic                   prev_i,
  output logic                   match_o,
  output logic                   hit_o
);
  import ncsm_pkg::*;

  logic match_q, match_d;
  logic active, tail, byte_eq;

  assign active  = LenW'(IDX) < len_i;
  assign tail    = LenW'(IDX + 1) == len_i;
  assign byte_eq = fold_case(needle_byte_i) == ctrl_i.text;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.step) begin
      match_d = prev_i & byte_eq & active;
    end
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;
  // full needle seen ending at this byte
  assign hit_o   = ctrl_i.step & prev_i & byte_eq & tail;

endmodule

// File: verif/ncsm_match_monitor.sv
// predictor and comparator that watches the needle registers and both stream channels
`timescale 1ns / 100ps
module ncsm_match_monitor #(
  parameter int unsigned MAX_NEEDLE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ncsm_pkg::ApbAddrW-1:0] paddr,
  input  logic [ncsm_pkg::ApbDataW-1:0] pwdata,
  ncsm_text_if                          text_i,
  ncsm_result_if                        result_i,
  output int unsigned                   pending_o,
  output int unsigned                   mismatch_o,
  output int unsigned                   checked_o,
  output int unsigned                   found_o
);
  import ncsm_pkg::*;

  logic [127:0] needle_q;
  logic [4:0]   needle_len_q;
  logic [15:0]  prefix_hits;
  logic         needle_seen;
  logic         found_expect_q[$];
  int unsigned  mismatches = 0;
  int unsigned  checked    = 0;
  int unsigned  found_cnt  = 0;

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c - CHAR_UPPER_A + CHAR_LOWER_A;
    end
    return c;
  endfunction

  // length actually used by the search, saturated to the needle storage
  function automatic int unsigned active_len(input logic [4:0] n);
    int unsigned k;
    k = n;
    if (k > RegBytes) k = RegBytes;
    if (k > MAX_NEEDLE) k = MAX_NEEDLE;
    return k;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    int unsigned len;
    logic [15:0] byte_hits;
    logic [7:0]  t;
    logic        want;
    if (!rst_ni) begin
      needle_q     = '0;
      needle_len_q = '0;
      prefix_hits  = '0;
      needle_seen  = 1'b0;
      found_expect_q.delete();
      pending_o  <= 0;
      mismatch_o <= 0;
      checked_o  <= 0;
      found_o    <= 0;
    end else begin
      // text transfer: advance the shift-and match vector
      if (text_i.valid && text_i.ready) begin
        len = active_len(needle_len_q);
        if (!text_i.haystack_empty && len > 0) begin
          t = lower_ascii(text_i.text_byte);
          byte_hits = '0;
          for (int i = 0; i < 16; i++) begin
            if (i < len && lower_ascii(needle_q[8*i +: 8]) == t) byte_hits[i] = 1'b1;
          end
          prefix_hits = {prefix_hits[14:0], 1'b1} & byte_hits;
          if (prefix_hits[len-1]) needle_seen = 1'b1;
        end
        if (text_i.is_last) begin
          found_expect_q.push_back(len == 0 || needle_seen);
          prefix_hits = '0;
          needle_seen = 1'b0;
        end
      end
      // register writes land after any text transfer of the same edge
      if (psel && penable && pwrite && pready) begin
        case (paddr[ApbAddrW-1 -: RegIdxW])
          REG_NEEDLE_LOW:  needle_q[63:0]   = pwdata[63:0];
          REG_NEEDLE_HIGH: needle_q[127:64] = pwdata[63:0];
          REG_NEEDLE_LEN:  needle_len_q     = pwdata[LenW-1:0];
          default: ;
        endcase
      end
      if (result_i.valid && result_i.ready) begin
        if (found_expect_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual found=%b", $time, result_i.found);
          mismatches++;
        end else begin
          want = found_expect_q.pop_front();
          checked++;
          if (result_i.found !== want) begin
            $display("%0t: found mismatch, expected %b actual %b", $time, want, result_i.found);
            mismatches++;
          end else if (want) begin
            found_cnt++;
          end
        end
      end
      pending_o  <= found_expect_q.size();
      mismatch_o <= mismatches;
      checked_o  <= checked;
      found_o    <= found_cnt;
    end
  end

endmodule

// File: verif/tb_nocase_substring_match.sv
// top of the substring matcher testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb_nocase_substring_match;
  import ncsm_pkg::*;

  localparam int unsigned MaxNeedle     = 16;
  localparam int unsigned RandPhases    = 10;
  localparam int unsigned PhaseItems    = 88;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [7:0]  CaseBit       = 8'h20;
  localparam logic [7:0]  LowerZ        = CHAR_LOWER_A + (CHAR_UPPER_Z - CHAR_UPPER_A);
  // directed long needle: letters, fold traps around the letter ranges, high and low bytes
  localparam logic [127:0] TrapNeedle   = 128'h3951e1c17b606e4d_017f80ff5b407a41;

  typedef logic [7:0] byte_q_t[$];

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  ncsm_text_if   text_ch ();
  ncsm_result_if result_ch ();

  // verdict inputs from the monitor
  int unsigned mon_pending;
  int unsigned mon_mismatch;
  int unsigned mon_checked;
  int unsigned mon_found;

  // run bookkeeping
  int unsigned text_sent    = 0;
  int unsigned haystacks    = 0;
  int unsigned settings     = 0;
  int unsigned quiet_cycles = 0;
  logic        calm         = 1'b0;  // no idling on either side while set
  logic [127:0] needle_now  = '0;
  int unsigned  needle_eff  = 0;

  nocase_substring_match #(
    .MAX_NEEDLE(MaxNeedle)
  ) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text_i  (text_ch),
    .result_o(result_ch)
  );

  ncsm_match_monitor #(
    .MAX_NEEDLE(MaxNeedle)
  ) u_match_monitor (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .text_i    (text_ch),
    .result_i  (result_ch),
    .pending_o (mon_pending),
    .mismatch_o(mon_mismatch),
    .checked_o (mon_checked),
    .found_o   (mon_found)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // gap length for either side: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // flip the case of ascii letters at random, leave everything else alone
  function automatic logic [7:0] vary_case(input logic [7:0] c);
    logic letter;
    letter = (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) || (c >= CHAR_LOWER_A && c <= LowerZ);
    if (letter && $urandom_range(0, 1) == 1) return c ^ CaseBit;
    return c;
  endfunction

  // the haystack never carries a zero byte
  function automatic logic [7:0] text_safe(input logic [7:0] c);
    return (c == 8'h00) ? 8'h01 : c;
  endfunction

  function automatic logic [7:0] needle_at(input int unsigned i);
    return needle_now[8*i +: 8];
  endfunction

  // small letter alphabet so that partial matches happen often
  function automatic logic [7:0] near_letter();
    return vary_case(CHAR_LOWER_A + 8'($urandom_range(0, 3)));
  endfunction

  function automatic logic [7:0] pick_needle_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'h00;
    if (r < 75) return near_letter();
    return random_byte();
  endfunction

  function automatic logic [4:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 5'd0;
      1: return 5'd1;
      2: return 5'd16;
      3: return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [7:0] filler();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r < 2 && needle_eff > 0) return vary_case(text_safe(needle_at($urandom_range(0, needle_eff - 1))));
    if (r < 3) return near_letter();
    return random_byte();
  endfunction

  // one haystack: now and then empty, else random lead-in, a needle copy, a near miss, a restart or filler, random tail
  function automatic byte_q_t make_haystack();
    byte_q_t hay;
    int unsigned kind;
    int unsigned miss;
    int unsigned cut;
    logic [7:0]  b;
    hay = {};
    kind = $urandom_range(0, 15);
    if (kind == 0) return hay;
    repeat ($urandom_range(0, 5)) hay.push_back(filler());
    if (kind <= 6) begin
      for (int i = 0; i < needle_eff; i++) hay.push_back(vary_case(text_safe(needle_at(i))));
    end else if (kind <= 9) begin
      // near miss: one needle byte replaced
      miss = (needle_eff > 0) ? $urandom_range(0, needle_eff - 1) : 0;
      for (int i = 0; i < needle_eff; i++) begin
        b = needle_at(i);
        if (i == miss) b = b + 8'($urandom_range(1, 255));
        hay.push_back(vary_case(text_safe(b)));
      end
    end else if (kind <= 11 && needle_eff > 1) begin
      // a broken start followed at once by the whole needle
      cut = $urandom_range(1, needle_eff - 1);
      for (int i = 0; i < cut; i++) hay.push_back(vary_case(text_safe(needle_at(i))));
      for (int i = 0; i < needle_eff; i++) hay.push_back(vary_case(text_safe(needle_at(i))));
    end else begin
      repeat ($urandom_range(1, 12)) hay.push_back(filler());
    end
    repeat ($urandom_range(0, 5)) hay.push_back(filler());
    if (hay.size() == 0) hay.push_back(filler());
    return hay;
  endfunction

  // present one text item and hold it until the transfer
  task automatic send_text(input logic [7:0] b, input logic last, input logic empty);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid          <= 1'b1;
    text_ch.text_byte      <= b;
    text_ch.is_last        <= last;
    text_ch.haystack_empty <= empty;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
  endtask

  task automatic send_haystack(input byte_q_t hay);
    haystacks++;
    if (hay.size() == 0) begin
      send_text(random_byte(), 1'b1, 1'b1);
      text_sent++;
    end else begin
      foreach (hay[i]) begin
        // occasional empty item without last, the block must ignore it
        if ($urandom_range(0, 24) == 0) send_text(random_byte(), 1'b0, 1'b1);
        send_text(hay[i], i == hay.size() - 1, 1'b0);
        text_sent++;
      end
    end
  endtask

  task automatic send_word(input string s);
    byte_q_t hay;
    hay = {};
    for (int i = 0; i < s.len(); i++) hay.push_back(s[i]);
    send_haystack(hay);
  endtask

  // drop valid and wait until every predicted result has been taken
  task automatic wait_idle();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (mon_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup cycle, then access cycle; then idle with psel low so the next write starts clean
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_needle(input logic [127:0] bytes, input logic [4:0] len);
    wait_idle();
    write_reg(REG_NEEDLE_LOW, bytes[63:0]);
    write_reg(REG_NEEDLE_HIGH, bytes[127:64]);
    write_reg(REG_NEEDLE_LEN, 64'(len));
    needle_now = bytes;
    needle_eff = (len > MaxNeedle) ? MaxNeedle : len;
    settings++;
  endtask

  // result side back-pressure, same gap profile as the sender
  initial begin : result_stall
    int unsigned hold;
    hold = 0;
    result_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // a run with no transfer and no register access for too long is hung
  always @(posedge clk) begin
    if (!rst_n || psel || (text_ch.valid && text_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [127:0] nv;
    logic [4:0]   nl;
    int unsigned  mark;
    byte_q_t      hay;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    text_ch.valid          = 1'b0;
    text_ch.text_byte      = 8'h01;
    text_ch.is_last        = 1'b0;
    text_ch.haystack_empty = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: empty needle, so found on a byte and on an empty haystack
    send_word("x");
    send_word("");

    // two byte needle "@Z": backquote must not fold onto '@', restart after a repeated '@'
    load_needle(128'h5a40, 5'd2);
    send_word("`z");
    send_text(8'h55, 1'b0, 1'b1);  // empty flag without last, ignored
    send_word("x@@z");
    send_word("");                 // empty haystack with a real needle: not found

    // oversized length saturates to the full sixteen byte needle
    load_needle(TrapNeedle, 5'd31);
    hay = {};
    for (int i = 0; i < 16; i++) hay.push_back(vary_case(needle_at(i)));
    send_haystack(hay);

    // random phases, first the all-ones and all-zeros register extremes
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        nv = '1;
        nl = 5'd16;
      end else if (p == 1) begin
        nv = '0;
        nl = 5'd0;
      end else begin
        for (int i = 0; i < 16; i++) nv[8*i +: 8] = pick_needle_byte();
        nl = pick_len();
      end
      load_needle(nv, nl);
      calm = ($urandom_range(0, 3) == 0);
      mark = text_sent;
      while (text_sent - mark < PhaseItems) begin
        send_haystack(make_haystack());
        // sender holds off now and then until the result stream has drained
        if ($urandom_range(0, 15) == 0) wait_idle();
      end
    end
    calm = 1'b0;
    wait_idle();

    $display("run covered %0d text items in %0d haystacks under %0d needle settings",
             text_sent, haystacks, settings);
    $display("%0d results compared, %0d of them reported the needle found",
             mon_checked, mon_found);
    if (mon_mismatch == 0 && mon_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ncsm_pkg.sv
hw/rtl/ncsm_if.sv
hw/rtl/ncsm_cell.sv
hw/rtl/nocase_substring_match.sv
verif/ncsm_match_monitor.sv
verif/tb_nocase_substring_match.sv
